/* rtl/core/uer_pkg.sv */
// Shared types and constants for the echo ranging core.
package uer_pkg;

  localparam int TrigWidthW = 8;
  localparam int TimeoutW   = 16;
  localparam int HoldoffW   = 20;
  localparam int TickW      = 20;
  localparam int DistW      = 11;
  localparam int CountW     = 16;
  localparam int CfgDataW   = 20;
  localparam int CfgIdxW    = 2;

  // Phase codes
  localparam logic [1:0] PH_TRIGGER = 2'd0;
  localparam logic [1:0] PH_WAIT    = 2'd1;
  localparam logic [1:0] PH_ECHO    = 2'd2;
  localparam logic [1:0] PH_HOLD    = 2'd3;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_TRIG_WIDTH = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_HOLDOFF    = 2'd2;

  // Register reset values
  localparam logic [TrigWidthW-1:0] TRIG_WIDTH_RST = 8'd10;
  localparam logic [TimeoutW-1:0]   TIMEOUT_RST    = 16'd10000;
  localparam logic [HoldoffW-1:0]   HOLDOFF_RST    = 20'd100000;

  // 0.017 cm per tick in Q16
  localparam logic [DistW-1:0] CM_PER_TICK_Q16 = 11'd1114;
  localparam int               DistProdW       = TickW + DistW;
  localparam logic [DistW-1:0] DIST_MAX        = {DistW{1'b1}};

  typedef struct packed {
    logic              trigger_level;
    logic [DistW-1:0]  distance_cm;
    logic              distance_new;
    logic              timed_out;
    logic [CountW-1:0] trigger_count;
  } uer_result_t;

endpackage

/* rtl/core/uer_dist.sv */
// Echo width to distance conversion: width*1114>>16, saturated to 11 bits.
module uer_dist
  import uer_pkg::*;
(
  input  logic [TickW-1:0] echo_ticks,
  output logic [DistW-1:0] dist_cm
);

  logic [DistProdW-1:0] prod;
  logic [DistProdW-17:0] scaled;

  assign prod   = DistProdW'(echo_ticks) * DistProdW'(CM_PER_TICK_Q16);
  assign scaled = prod[DistProdW-1:16];

  // echo width stays within the 16-bit timeout, so the clamp never engages
  assign dist_cm = (scaled > (DistProdW-16)'(DIST_MAX)) ? DIST_MAX : scaled[DistW-1:0];

endmodule

/* rtl/core/ultrasonic_echo_ranger_core.sv */
// Echo ranging controller top level: trigger pulse, echo timing and distance output.
// One input beat is one microsecond tick carrying the sampled echo level; each
// accepted beat yields exactly one result beat, registered in the next cycle. The core
// takes a beat every clock cycle while out_ready is high; a finished result that
// waits on out_ready holds in_ready low, because input readiness needs the result
// register to be empty or draining this cycle. in_ready is also low during reset.
// Throughput is one beat per cycle while out_ready is high; the single-step phase
// update (one 20-bit add and compare and one 20x11 multiply) lies between the tick
// state and the result register. The trigger is driven
// for trigger_width ticks (zero acts as one), then the core waits for an echo
// rising edge, times the high period, and converts it to centimeters at the
// falling edge. A missing or overlong echo raises timed_out and retriggers at once;
// a good echo raises distance_new and starts holdoff_time ticks of pause.
// Register writes on the cfg port take effect on the next tick and should be made
// while no beat is in flight.
module ultrasonic_echo_ranger_core
  import uer_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  // tick input
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_echo_level,
  // result output
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_trigger_level,
  output logic [DistW-1:0]    out_distance_cm,
  output logic                out_distance_new,
  output logic                out_timed_out,
  output logic [CountW-1:0]   out_trigger_count
);

  // config registers
  logic [TrigWidthW-1:0] trig_width_r;
  logic [TimeoutW-1:0]   timeout_r;
  logic [HoldoffW-1:0]   holdoff_r;

  // tick state
  logic [1:0]        phase_r, phase_nxt;
  logic [TickW-1:0]  tick_r, tick_nxt;
  logic              echo_prev_r;
  logic [DistW-1:0]  dist_r, dist_nxt;
  logic [CountW-1:0] trig_cnt_r, trig_cnt_nxt;

  // result register
  logic        out_valid_r;
  uer_result_t res_r, res_nxt;

  logic              in_acc;
  logic [TickW-1:0]  tick_inc;
  logic [TrigWidthW-1:0] width_lim;
  logic [DistW-1:0]  dist_conv;
  logic              trig, fresh, tmo;

  assign in_ready = rst_n && (!out_valid_r || out_ready);
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_width_r <= TRIG_WIDTH_RST;
      timeout_r    <= TIMEOUT_RST;
      holdoff_r    <= HOLDOFF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TRIG_WIDTH: trig_width_r <= cfg_data[TrigWidthW-1:0];
        REG_TIMEOUT:    timeout_r    <= cfg_data[TimeoutW-1:0];
        REG_HOLDOFF:    holdoff_r    <= cfg_data[HoldoffW-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  uer_dist u_dist (
    .echo_ticks (tick_r),
    .dist_cm    (dist_conv)
  );

  assign tick_inc  = tick_r + TickW'(1);
  assign width_lim = (trig_width_r == '0) ? TrigWidthW'(1) : trig_width_r;

  // one tick of the phase machine
  always_comb begin
    phase_nxt    = phase_r;
    tick_nxt     = tick_inc;
    dist_nxt     = dist_r;
    trig_cnt_nxt = trig_cnt_r;
    trig         = 1'b0;
    fresh        = 1'b0;
    tmo          = 1'b0;
    unique case (phase_r)
      PH_TRIGGER: begin
        trig = 1'b1;
        if (tick_inc >= TickW'(width_lim)) begin
          phase_nxt    = PH_WAIT;
          tick_nxt     = '0;
          trig_cnt_nxt = trig_cnt_r + CountW'(1);
        end
      end
      PH_WAIT: begin
        if (in_echo_level && !echo_prev_r) begin
          // rising edge counts as the first echo tick
          if (timeout_r == '0) begin
            tmo       = 1'b1;
            phase_nxt = PH_TRIGGER;
            tick_nxt  = '0;
          end else begin
            phase_nxt = PH_ECHO;
            tick_nxt  = TickW'(1);
          end
        end else if (tick_inc > TickW'(timeout_r)) begin
          tmo       = 1'b1;
          phase_nxt = PH_TRIGGER;
          tick_nxt  = '0;
        end
      end
      PH_ECHO: begin
        if (!in_echo_level) begin
          dist_nxt  = dist_conv;
          fresh     = 1'b1;
          tick_nxt  = '0;
          phase_nxt = (holdoff_r == '0) ? PH_TRIGGER : PH_HOLD;
        end else if (tick_inc > TickW'(timeout_r)) begin
          tmo       = 1'b1;
          phase_nxt = PH_TRIGGER;
          tick_nxt  = '0;
        end
      end
      PH_HOLD: begin
        if (tick_inc >= holdoff_r) begin
          phase_nxt = PH_TRIGGER;
          tick_nxt  = '0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res_nxt.trigger_level = trig;
    res_nxt.distance_cm   = dist_nxt;
    res_nxt.distance_new  = fresh;
    res_nxt.timed_out     = tmo;
    res_nxt.trigger_count = trig_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TRIGGER;
      tick_r      <= '0;
      echo_prev_r <= 1'b0;
      dist_r      <= '0;
      trig_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r     <= phase_nxt;
        tick_r      <= tick_nxt;
        echo_prev_r <= in_echo_level;
        dist_r      <= dist_nxt;
        trig_cnt_r  <= trig_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_trigger_level = res_r.trigger_level;
  assign out_distance_cm   = res_r.distance_cm;
  assign out_distance_new  = res_r.distance_new;
  assign out_timed_out     = res_r.timed_out;
  assign out_trigger_count = res_r.trigger_count;

  // a tick never both completes and times out a measurement
  a_new_xor_tmo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_distance_new && out_timed_out))
    else $error("distance_new and timed_out both set");

  // holdoff ticks are quiet on every flag
  a_hold_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && phase_r == PH_HOLD) |=>
      (!out_trigger_level && !out_distance_new && !out_timed_out))
    else $error("activity flagged during holdoff");

  // falling echo edge during the echo phase always reports a distance
  a_fall_reports: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && phase_r == PH_ECHO && !in_echo_level) |=>
      (out_distance_new && out_distance_cm == dist_r))
    else $error("echo falling edge did not report distance");

  // trigger count moves only on a trigger beat
  a_count_on_trig: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && phase_r != PH_TRIGGER) |=> $stable(trig_cnt_r))
    else $error("trigger count moved outside trigger phase");

endmodule
